@@ rtl/nmea_sentence_checker_top_assert.svh @@
// Assertion macros for the NMEA sentence checker.
// No dependencies; included by modules that check their own logic.
`ifndef NMEA_SENTENCE_CHECKER_TOP_ASSERT_SVH
`define NMEA_SENTENCE_CHECKER_TOP_ASSERT_SVH
`ifndef SYNTH
`define NSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define NSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define NSC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define NSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/nsc_pkg.sv @@
// Package for the NMEA sentence checker: character codes, types, tag tables.
// No dependencies.
package nsc_pkg;

    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_FIX_A     = 8'h41;
    localparam logic [7:0] CH_DIGIT_0   = 8'd48;
    localparam logic [7:0] CH_DIGIT_9   = 8'd57;
    localparam logic [7:0] CH_HEX_A     = 8'd65;
    localparam logic [7:0] CH_DIGIT_TOP = 8'd70;
    localparam logic [7:0] HEX_A_OFFSET = 8'd55;
    localparam logic [7:0] MAX_LINE_RESET = 8'd82;
    localparam logic [2:0] TAG_LEN      = 3'd5;
    localparam logic [2:0] TAG_POS_MAX  = 3'd7;
    localparam logic [4:0] COUNT_MAX    = 5'd31;

    typedef enum logic [1:0] {
        PH_PAYLOAD = 2'd0,
        PH_DIGITS  = 2'd1,
        PH_TRAILER = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_RMC   = 2'd1,
        KIND_GGA   = 2'd2
    } t_kind;

    function automatic logic [7:0] tag_rmc_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h47; // G
            3'd1:    c = 8'h50; // P
            3'd2:    c = 8'h52; // R
            3'd3:    c = 8'h4D; // M
            default: c = 8'h43; // C
        endcase
        return c;
    endfunction

    function automatic logic [7:0] tag_gga_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h47; // G
            3'd1:    c = 8'h50; // P
            3'd2:    c = 8'h47; // G
            3'd3:    c = 8'h47; // G
            default: c = 8'h41; // A
        endcase
        return c;
    endfunction

endpackage

@@ rtl/nmea_sentence_checker_top.sv @@
// NMEA sentence checker: checksum, field split, tag and fix decode per byte.
// Depends on nsc_pkg and nmea_sentence_checker_top_assert.svh.
//
//  channel  direction  handshake                 word
//  in       sink       i_in_valid / o_in_stall   i_rx_byte
//  out      source     o_out_valid / i_out_stall data_byte .. fix_active
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_data (max_line_index)
//
// One byte per cycle sustained while i_out_stall is low; each byte passes the input register, then the result register.
// Sentence state updates as the byte moves from the input to the result register.
// Synchronous active-low reset; no clearing pass, ready on the cycle after reset.
// An output stall holds the result; the input register still takes one more byte if it is empty.
// cfg is always ready.
`include "nmea_sentence_checker_top_assert.svh"

module nmea_sentence_checker_top
    import nsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_data_byte,
    output logic [4:0] o_field_number,
    output logic       o_is_payload,
    output logic [1:0] o_sentence_kind,
    output logic       o_line_end,
    output logic       o_checksum_ok,
    output logic [4:0] o_empty_count,
    output logic       o_fix_active,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_out_valid;
    logic       out_free;
    logic       s1_go;

    logic [7:0] r_max_line;

    t_phase     r_phase, n_phase, u_phase;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_rsum, n_rsum;
    logic [1:0] r_dcount, n_dcount;
    logic       r_dbad, n_dbad;
    logic [4:0] r_field, n_field;
    logic       r_has_char, n_has_char;
    logic [4:0] r_empty, n_empty;
    logic [7:0] r_line_len, n_line_len;
    logic       r_last_cr, n_last_cr;
    logic [2:0] r_tag_pos, n_tag_pos;
    logic [1:0] r_tag_flags, n_tag_flags;
    t_kind      r_kind, n_kind;
    logic       r_fix, n_fix;

    logic [7:0] u_xor, u_rsum;
    logic [1:0] u_dcount;
    logic       u_dbad;
    logic [4:0] u_field, u_empty;
    logic       u_has_char;
    logic [2:0] u_tag_pos;
    logic [1:0] u_tag_flags;
    t_kind      u_kind;
    logic       u_fix;

    logic [7:0] b;
    logic       ends;
    logic       payload;
    logic       inc_empty;
    logic [3:0] digit_val;
    logic [7:0] rx_sum;
    logic       ok;

    logic [7:0] r_o_data;
    logic [4:0] r_o_field;
    logic       r_o_payload;
    logic [1:0] r_o_kind;
    logic       r_o_end;
    logic       r_o_ok;
    logic [4:0] r_o_empty;
    logic       r_o_fix;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_go      = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign o_cfg_ready = 1'b1;

    assign b    = r_s1_byte;
    assign ends = (b == CH_LF && r_last_cr) || (r_line_len >= r_max_line);
    assign inc_empty = (r_field != 5'd0) && !r_has_char && (r_empty != COUNT_MAX);

    // phase next state
    always_comb begin
        u_phase = r_phase;
        if (b == CH_DOLLAR) begin
            u_phase = PH_PAYLOAD;
        end else begin
            unique case (r_phase)
                PH_PAYLOAD: begin
                    if (b == CH_STAR) u_phase = PH_DIGITS;
                end
                PH_DIGITS: begin
                    if (b < CH_DIGIT_0 || b > CH_DIGIT_TOP) u_phase = PH_TRAILER;
                end
                default: u_phase = r_phase;
            endcase
        end
        n_phase = ends ? PH_PAYLOAD : u_phase;
    end

    // sentence datapath
    always_comb begin
        u_xor       = r_xor;
        u_rsum      = r_rsum;
        u_dcount    = r_dcount;
        u_dbad      = r_dbad;
        u_field     = r_field;
        u_has_char  = r_has_char;
        u_empty     = r_empty;
        u_tag_pos   = r_tag_pos;
        u_tag_flags = r_tag_flags;
        u_kind      = r_kind;
        u_fix       = r_fix;
        payload     = 1'b0;
        digit_val   = 4'd0;

        if (b == CH_DOLLAR) begin
            u_xor       = 8'd0;
            u_rsum      = 8'd0;
            u_dcount    = 2'd0;
            u_dbad      = 1'b0;
            u_field     = 5'd0;
            u_has_char  = 1'b0;
            u_empty     = 5'd0;
            u_tag_pos   = 3'd0;
            u_tag_flags = 2'b11;
            u_kind      = KIND_OTHER;
            u_fix       = 1'b0;
        end else begin
            unique case (r_phase)
                PH_PAYLOAD: begin
                    if (b == CH_STAR) begin
                        u_empty  = r_empty + {4'd0, inc_empty};
                        u_rsum   = 8'd0;
                        u_dcount = 2'd0;
                        u_dbad   = 1'b0;
                    end else if (b == CH_COMMA) begin
                        u_empty = r_empty + {4'd0, inc_empty};
                        if (r_field == 5'd0) begin
                            if (r_tag_pos == TAG_LEN && r_tag_flags[0]) begin
                                u_kind = KIND_RMC;
                            end else if (r_tag_pos == TAG_LEN && r_tag_flags[1]) begin
                                u_kind = KIND_GGA;
                            end else begin
                                u_kind = KIND_OTHER;
                            end
                        end
                        if (r_field != COUNT_MAX) u_field = r_field + 5'd1;
                        u_has_char = 1'b0;
                        u_xor      = r_xor ^ b;
                    end else if (b != CH_CR && b != CH_LF) begin
                        payload = 1'b1;
                        u_xor   = r_xor ^ b;
                        if (r_field == 5'd0) begin
                            if (r_tag_pos < TAG_LEN) begin
                                u_tag_flags[0] = r_tag_flags[0] && (b == tag_rmc_char(r_tag_pos));
                                u_tag_flags[1] = r_tag_flags[1] && (b == tag_gga_char(r_tag_pos));
                            end else begin
                                u_tag_flags = 2'b00;
                            end
                            if (r_tag_pos < TAG_POS_MAX) u_tag_pos = r_tag_pos + 3'd1;
                        end
                        if (r_kind == KIND_RMC && r_field == 5'd2 && !r_has_char
                            && b == CH_FIX_A) begin
                            u_fix = 1'b1;
                        end
                        u_has_char = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    if (b >= CH_DIGIT_0 && b <= CH_DIGIT_TOP) begin
                        if (b <= CH_DIGIT_9) begin
                            digit_val = 4'(b - CH_DIGIT_0);
                        end else if (b >= CH_HEX_A) begin
                            digit_val = 4'(b - HEX_A_OFFSET);
                        end else begin
                            u_dbad = 1'b1;
                        end
                        if (r_dcount < 2'd2) u_rsum = {r_rsum[3:0], digit_val};
                        if (r_dcount != 2'd3) u_dcount = r_dcount + 2'd1;
                    end
                end
                default: ;
            endcase
        end

        rx_sum = (u_dcount != 2'd0 && u_dcount != 2'd3 && !u_dbad) ? u_rsum : 8'd0;
        ok     = (u_phase != PH_PAYLOAD) && (rx_sum == u_xor);

        if (ends) begin
            n_xor       = 8'd0;
            n_rsum      = 8'd0;
            n_dcount    = 2'd0;
            n_dbad      = 1'b0;
            n_field     = 5'd0;
            n_has_char  = 1'b0;
            n_empty     = 5'd0;
            n_tag_pos   = 3'd0;
            n_tag_flags = 2'b11;
            n_kind      = KIND_OTHER;
            n_fix       = 1'b0;
            n_line_len  = 8'd0;
            n_last_cr   = 1'b0;
        end else begin
            n_xor       = u_xor;
            n_rsum      = u_rsum;
            n_dcount    = u_dcount;
            n_dbad      = u_dbad;
            n_field     = u_field;
            n_has_char  = u_has_char;
            n_empty     = u_empty;
            n_tag_pos   = u_tag_pos;
            n_tag_flags = u_tag_flags;
            n_kind      = u_kind;
            n_fix       = u_fix;
            n_line_len  = (r_line_len != 8'hFF) ? r_line_len + 8'd1 : r_line_len;
            n_last_cr   = (b == CH_CR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_line  <= MAX_LINE_RESET;
            r_phase     <= PH_PAYLOAD;
            r_xor       <= 8'd0;
            r_rsum      <= 8'd0;
            r_dcount    <= 2'd0;
            r_dbad      <= 1'b0;
            r_field     <= 5'd0;
            r_has_char  <= 1'b0;
            r_empty     <= 5'd0;
            r_line_len  <= 8'd0;
            r_last_cr   <= 1'b0;
            r_tag_pos   <= 3'd0;
            r_tag_flags <= 2'b11;
            r_kind      <= KIND_OTHER;
            r_fix       <= 1'b0;
        end else begin
            if (i_cfg_valid) r_max_line <= i_cfg_data;
            if (!o_in_stall) r_s1_valid <= i_in_valid;
            if (out_free) r_out_valid <= r_s1_valid;
            if (s1_go) begin
                r_phase     <= n_phase;
                r_xor       <= n_xor;
                r_rsum      <= n_rsum;
                r_dcount    <= n_dcount;
                r_dbad      <= n_dbad;
                r_field     <= n_field;
                r_has_char  <= n_has_char;
                r_empty     <= n_empty;
                r_line_len  <= n_line_len;
                r_last_cr   <= n_last_cr;
                r_tag_pos   <= n_tag_pos;
                r_tag_flags <= n_tag_flags;
                r_kind      <= n_kind;
                r_fix       <= n_fix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) r_s1_byte <= i_rx_byte;
        if (s1_go) begin
            r_o_data    <= b;
            r_o_field   <= r_field;
            r_o_payload <= payload;
            r_o_kind    <= u_kind;
            r_o_end     <= ends;
            r_o_ok      <= ends && ok;
            r_o_empty   <= ends ? u_empty : 5'd0;
            r_o_fix     <= ends && u_fix && (u_kind == KIND_RMC);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_data_byte     = r_o_data;
    assign o_field_number  = r_o_field;
    assign o_is_payload    = r_o_payload;
    assign o_sentence_kind = r_o_kind;
    assign o_line_end      = r_o_end;
    assign o_checksum_ok   = r_o_ok;
    assign o_empty_count   = r_o_empty;
    assign o_fix_active    = r_o_fix;

    `NSC_ASSERT_SAME(a_verdict_only_at_end, i_clk, i_rst_n, o_out_valid && !o_line_end, !o_checksum_ok && o_empty_count == 5'd0 && !o_fix_active)
    `NSC_ASSERT_SAME(a_fix_needs_rmc, i_clk, i_rst_n, o_out_valid && o_fix_active, o_sentence_kind == KIND_RMC)
    `NSC_ASSERT_NEXT(a_end_clears_length, i_clk, i_rst_n, s1_go && ends, r_line_len == 8'd0 && r_field == 5'd0)
    `NSC_ASSERT_SAME(a_empty_needs_field, i_clk, i_rst_n, r_empty != 5'd0, r_field != 5'd0)

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for nmea_sentence_checker_top: byte stream in, per-byte
// result word out, line limit register. Depends on nsc_pkg and the checker RTL.
`timescale 1ns / 1ps

module tb;
    import nsc_pkg::*;

    localparam int          QUIET_LIMIT = 2000;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [7:0]  LIMIT_MIN   = 8'd1;
    localparam logic [7:0]  LIMIT_MAX   = 8'd255;
    localparam logic [7:0]  LIMIT_SHORT = 8'd20;
    localparam logic [39:0] RMC_TAG     = "GPRMC";
    localparam logic [39:0] GGA_TAG     = "GPGGA";
    localparam logic [7:0]  CH_LOWER_A  = "a";

    typedef struct packed {
        logic [7:0] data;
        logic [4:0] field;
        logic       payload;
        t_kind      kind;
        logic       line_end;
        logic       sum_ok;
        logic [4:0] empties;
        logic       fix;
    } t_nmea_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_rx_byte = '0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_data_byte;
    logic [4:0] o_field_number;
    logic       o_is_payload;
    logic [1:0] o_sentence_kind;
    logic       o_line_end;
    logic       o_checksum_ok;
    logic [4:0] o_empty_count;
    logic       o_fix_active;
    logic       o_cfg_ready;

    nmea_sentence_checker_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_data_byte     (o_data_byte),
        .o_field_number  (o_field_number),
        .o_is_payload    (o_is_payload),
        .o_sentence_kind (o_sentence_kind),
        .o_line_end      (o_line_end),
        .o_checksum_ok   (o_checksum_ok),
        .o_empty_count   (o_empty_count),
        .o_fix_active    (o_fix_active),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // sentence tracker state
    t_phase     ph;
    t_kind      kind;
    logic [7:0] xsum, rx_sum, line_len, line_limit;
    logic [1:0] ndigits, tag_flags;
    logic [4:0] field_cnt, empty_cnt;
    logic [2:0] tag_pos;
    logic       digit_err, field_used, prev_cr, fix_seen;

    t_nmea_word pending_words[$];
    logic [7:0] line_buf[$];
    t_nmea_word seen_word, due_word;
    int         mismatches = 0;
    int         sent_count = 0;
    int         lines_closed = 0, lines_good = 0, fixes_seen = 0, cfg_writes = 0;
    int         quiet_cycles = 0;
    bit         in_gaps_on = 1'b0, out_stalls_on = 1'b0, hold_req = 1'b0;

    function automatic void restart_sentence();
        ph = PH_PAYLOAD;
        xsum = '0;
        rx_sum = '0;
        ndigits = '0;
        digit_err = 1'b0;
        field_cnt = '0;
        field_used = 1'b0;
        empty_cnt = '0;
        tag_pos = '0;
        tag_flags = 2'b11;
        kind = KIND_OTHER;
        fix_seen = 1'b0;
    endfunction

    function automatic void close_open_field();
        if (field_cnt >= 1 && !field_used && empty_cnt != COUNT_MAX)
            empty_cnt++;
    endfunction

    function automatic t_nmea_word predict_byte(input logic [7:0] b);
        t_nmea_word w;
        logic       ends;
        logic [7:0] dval, rx;
        w = '0;
        w.data = b;
        w.field = field_cnt;
        ends = (b == CH_LF && prev_cr) || (line_len >= line_limit);
        if (b == CH_DOLLAR) begin
            restart_sentence();
        end else if (ph == PH_PAYLOAD) begin
            if (b == CH_STAR) begin
                close_open_field();
                ph = PH_DIGITS;
                rx_sum = '0;
                ndigits = '0;
                digit_err = 1'b0;
            end else if (b == CH_COMMA) begin
                close_open_field();
                if (field_cnt == 0) begin
                    if (tag_pos == TAG_LEN && tag_flags[0])
                        kind = KIND_RMC;
                    else if (tag_pos == TAG_LEN && tag_flags[1])
                        kind = KIND_GGA;
                    else
                        kind = KIND_OTHER;
                end
                if (field_cnt != COUNT_MAX)
                    field_cnt++;
                field_used = 1'b0;
                xsum ^= b;
            end else if (b != CH_CR && b != CH_LF) begin
                w.payload = 1'b1;
                xsum ^= b;
                if (field_cnt == 0) begin
                    if (tag_pos < TAG_LEN) begin
                        if (b != RMC_TAG[39 - 8 * tag_pos -: 8])
                            tag_flags[0] = 1'b0;
                        if (b != GGA_TAG[39 - 8 * tag_pos -: 8])
                            tag_flags[1] = 1'b0;
                    end else begin
                        tag_flags = 2'b00;
                    end
                    if (tag_pos < TAG_POS_MAX)
                        tag_pos++;
                end
                if (kind == KIND_RMC && field_cnt == 2 && !field_used && b == CH_FIX_A)
                    fix_seen = 1'b1;
                field_used = 1'b1;
            end
        end else if (ph == PH_DIGITS) begin
            if (b >= CH_DIGIT_0 && b <= CH_DIGIT_TOP) begin
                dval = '0;
                if (b <= CH_DIGIT_9)
                    dval = b - CH_DIGIT_0;
                else if (b >= CH_HEX_A)
                    dval = b - CH_HEX_A + 8'd10;
                else
                    digit_err = 1'b1;
                if (ndigits < 2)
                    rx_sum = {rx_sum[3:0], dval[3:0]};
                if (ndigits < 3)
                    ndigits++;
            end else begin
                ph = PH_TRAILER;
            end
        end
        w.kind = kind;
        if (ends) begin
            rx = (ndigits >= 1 && ndigits <= 2 && !digit_err) ? rx_sum : 8'd0;
            w.line_end = 1'b1;
            w.sum_ok = (ph != PH_PAYLOAD) && (rx == xsum);
            w.empties = empty_cnt;
            w.fix = fix_seen && kind == KIND_RMC;
            restart_sentence();
            line_len = '0;
            prev_cr = 1'b0;
        end else begin
            if (line_len != 8'd255)
                line_len++;
            prev_cr = (b == CH_CR);
        end
        return w;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(8'h20, 8'h7E));
        while (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 10)
            return CH_DIGIT_0 + 8'(n);
        return (lower ? CH_LOWER_A : CH_HEX_A) + 8'(n) - 8'd10;
    endfunction

    function automatic void push_sum(input logic [7:0] v, input bit lower);
        line_buf.push_back(hex_char(v[7:4], lower));
        line_buf.push_back(hex_char(v[3:0], lower));
    endfunction

    // pushes the text, returns the XOR of everything but the dollar and star
    function automatic logic [7:0] push_text(input string s);
        logic [7:0] sum;
        sum = '0;
        for (int i = 0; i < s.len(); i++) begin
            line_buf.push_back(s[i]);
            if (s[i] != CH_DOLLAR && s[i] != CH_STAR)
                sum ^= s[i];
        end
        return sum;
    endfunction

    task automatic make_sentence(input bit long_mode);
        logic [39:0] tag;
        logic [7:0]  sum, c;
        int unsigned r, nf, n, pos;
        line_buf.delete();
        sum = '0;
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 16))
                line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            line_buf.push_back(CH_DOLLAR);
            r = $urandom_range(0, 99);
            if (r < 40)
                tag = RMC_TAG;
            else if (r < 75)
                tag = GGA_TAG;
            else
                tag = $urandom_range(0, 1) ? RMC_TAG : GGA_TAG;
            if (r < 88) begin
                if (r >= 75) begin
                    pos = $urandom_range(0, 4);
                    tag[39 - 8 * pos -: 8] = text_char();
                end
                for (int p = 0; p < 5; p++) begin
                    c = tag[39 - 8 * p -: 8];
                    line_buf.push_back(c);
                    sum ^= c;
                end
            end else begin
                repeat ($urandom_range(0, 7)) begin
                    c = text_char();
                    line_buf.push_back(c);
                    sum ^= c;
                end
            end
            nf = long_mode ? $urandom_range(30, 40) : $urandom_range(0, 12);
            for (int f = 1; f <= nf; f++) begin
                line_buf.push_back(CH_COMMA);
                sum ^= CH_COMMA;
                if (f == 2 && $urandom_range(0, 1)) begin
                    c = ($urandom_range(0, 3) != 0) ? CH_FIX_A : text_char();
                    line_buf.push_back(c);
                    sum ^= c;
                end
                n = ($urandom_range(0, 99) < (long_mode ? 75 : 30)) ? 0 : $urandom_range(1, 6);
                repeat (n) begin
                    c = text_char();
                    line_buf.push_back(c);
                    sum ^= c;
                end
            end
            if ($urandom_range(0, 99) < 92) begin
                line_buf.push_back(CH_STAR);
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    push_sum(sum, 1'b0);
                end else if (r < 78) begin
                    push_sum(sum, 1'b1);
                end else if (r < 84) begin
                    // star with no digits
                end else if (r < 90) begin
                    push_sum(sum, 1'b0);
                    line_buf.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
                end else begin
                    repeat ($urandom_range(1, 3))
                        line_buf.push_back(8'($urandom_range(CH_DIGIT_0, CH_DIGIT_TOP)));
                end
            end
            r = $urandom_range(0, 99);
            if (r < 85 || r >= 95)
                line_buf.push_back(CH_CR);
            if (r >= 95)
                line_buf.push_back(8'($urandom_range(0, 255)));
            if (r < 85 || r >= 90)
                line_buf.push_back(CH_LF);
        end
        if ($urandom_range(0, 99) < 10)
            line_buf.insert($urandom_range(0, line_buf.size() - 1),
                            8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 4)
            line_buf.insert($urandom_range(0, line_buf.size() - 1), CH_DOLLAR);
    endtask

    task automatic send_rx_byte(input logic [7:0] b);
        int unsigned gap;
        i_rx_byte <= b;
        i_in_valid <= 1'b1;
        do
            @(posedge i_clk);
        while (o_in_stall);
        pending_words.push_back(predict_byte(b));
        sent_count++;
        gap = in_gaps_on ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_buffer();
        foreach (line_buf[i])
            send_rx_byte(line_buf[i]);
    endtask

    task automatic drain_output();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_line_limit(input logic [7:0] v);
        drain_output();
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        line_limit = v;
        cfg_writes++;
    endtask

    task automatic send_random_lines(input int upto, input bit long_mode);
        while (sent_count < upto) begin
            make_sentence(long_mode);
            send_buffer();
        end
    endtask

    task automatic test_directed_lines();
        logic [7:0] sum;
        line_buf.delete();
        // RMC with empty field, active fix, good checksum
        sum = push_text("$GPRMC,,A,*");
        push_sum(sum, 1'b0);
        void'(push_text("\r\n"));
        // extreme bytes, restart mid tag, GGA, single digit then a bad one
        line_buf.push_back(8'h00);
        void'(push_text("$G$GPGGA,"));
        line_buf.push_back(8'hFF);
        void'(push_text(",*1:\r\n"));
        // no star at all
        void'(push_text("$G\r\n"));
        send_buffer();
        drain_output();
    endtask

    task automatic test_random_default_limit();
        write_line_limit(MAX_LINE_RESET);
        in_gaps_on = 1'b0;
        out_stalls_on = 1'b0;
        send_random_lines(sent_count + 200, 1'b0);
        in_gaps_on = 1'b1;
        out_stalls_on = 1'b1;
        send_random_lines(sent_count + 250, 1'b0);
        drain_output();
    endtask

    task automatic test_shortest_limits();
        write_line_limit(LIMIT_MIN);
        send_random_lines(sent_count + 80, 1'b0);
        write_line_limit(LIMIT_SHORT);
        send_random_lines(sent_count + 120, 1'b0);
        drain_output();
    endtask

    task automatic test_longest_limit();
        write_line_limit(LIMIT_MAX);
        send_random_lines(sent_count + 220, 1'b1);
        // unterminated line, closed by the limit
        line_buf.delete();
        line_buf.push_back(CH_DOLLAR);
        repeat (270)
            line_buf.push_back(text_char());
        send_buffer();
        send_random_lines(sent_count + 60, 1'b1);
        drain_output();
    endtask

    task automatic test_output_hold();
        write_line_limit(MAX_LINE_RESET);
        in_gaps_on = 1'b0;
        hold_req = 1'b1;
        send_random_lines(sent_count + 200, 1'b0);
        drain_output();
        in_gaps_on = 1'b1;
    endtask

    task automatic test_random_limits();
        while (sent_count < 1500) begin
            write_line_limit(8'($urandom_range(24, 120)));
            send_random_lines(sent_count + 100, $urandom_range(0, 4) == 0);
        end
        drain_output();
    endtask

    // output stall driver
    initial begin
        int unsigned n;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (out_stalls_on && $urandom_range(0, 99) < 35) begin
                n = pick_gap();
                if (n != 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_word.data = o_data_byte;
            seen_word.field = o_field_number;
            seen_word.payload = o_is_payload;
            seen_word.kind = t_kind'(o_sentence_kind);
            seen_word.line_end = o_line_end;
            seen_word.sum_ok = o_checksum_ok;
            seen_word.empties = o_empty_count;
            seen_word.fix = o_fix_active;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: byte %h field %0d", o_data_byte,
                             o_field_number);
            end else begin
                due_word = pending_words.pop_front();
                if (seen_word.data !== due_word.data || seen_word.field !== due_word.field ||
                    seen_word.payload !== due_word.payload ||
                    seen_word.kind !== due_word.kind ||
                    seen_word.line_end !== due_word.line_end ||
                    seen_word.sum_ok !== due_word.sum_ok ||
                    seen_word.empties !== due_word.empties ||
                    seen_word.fix !== due_word.fix) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch: exp byte %h fld %0d pay %b kind %0d",
                               due_word.data, due_word.field, due_word.payload,
                               due_word.kind);
                        $display(" end %b ok %b empty %0d fix %b",
                                 due_word.line_end, due_word.sum_ok,
                                 due_word.empties, due_word.fix);
                        $write("          got byte %h fld %0d pay %b kind %0d",
                               seen_word.data, seen_word.field, seen_word.payload,
                               seen_word.kind);
                        $display(" end %b ok %b empty %0d fix %b",
                                 seen_word.line_end, seen_word.sum_ok,
                                 seen_word.empties, seen_word.fix);
                    end
                end
                if (due_word.line_end) begin
                    lines_closed++;
                    lines_good += due_word.sum_ok;
                    fixes_seen += due_word.fix;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL nmea_sentence_checker_top");
                $finish;
            end
        end
    end

    initial begin
        restart_sentence();
        line_len = '0;
        prev_cr = 1'b0;
        line_limit = MAX_LINE_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_directed_lines();
        test_random_default_limit();
        test_shortest_limits();
        test_longest_limit();
        test_output_hold();
        test_random_limits();
        $display("covered %0d bytes, %0d closed lines (%0d good checksums, %0d RMC fixes)",
                 sent_count, lines_closed, lines_good, fixes_seen);
        $display("line limit written %0d times, from %0d up to %0d; %0d mismatches",
                 cfg_writes, LIMIT_MIN, LIMIT_MAX, mismatches);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("PASS nmea_sentence_checker_top");
        else
            $display("FAIL nmea_sentence_checker_top");
        $finish;
    end

endmodule
